@@ rtl/tpi_pkg.sv @@
package tpi_pkg;

    // Stack and queue sizing
    localparam int STACK_DEPTH = 64;
    localparam int STK_IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STK_LVL_W   = $clog2(STACK_DEPTH + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_TURN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_TURN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DIR_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DIR_Y = 2'd3;

    // Reset values
    localparam logic signed [15:0] COS_TURN_RESET    = 16'sd16384;
    localparam logic signed [15:0] SIN_TURN_RESET    = 16'sd0;
    localparam logic signed [15:0] START_DIR_X_RESET = 16'sd16384;
    localparam logic signed [15:0] START_DIR_Y_RESET = 16'sd0;
    localparam logic [15:0]        DEPTH_ONE         = 16'd1;
    localparam logic [15:0]        DEPTH_MAX         = 16'hFFFF;

    // Symbols
    localparam logic [7:0] SYM_F      = 8'h46;
    localparam logic [7:0] SYM_G      = 8'h47;
    localparam logic [7:0] SYM_PUSH   = 8'h5B;
    localparam logic [7:0] SYM_POP    = 8'h5D;
    localparam logic [7:0] SYM_PLUS   = 8'h2B;
    localparam logic [7:0] SYM_MINUS  = 8'h2D;

    // Result status codes
    localparam logic [1:0] ST_VERTEX    = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DRAW,
        OP_PUSH,
        OP_POP,
        OP_TURN_PLUS,
        OP_TURN_MINUS
    } op_t;

    typedef struct packed {
        op_t  op;
        logic restart;
    } queue_entry_t;

    typedef struct packed {
        logic signed [15:0] cos_turn;
        logic signed [15:0] sin_turn;
        logic signed [15:0] start_dir_x;
        logic signed [15:0] start_dir_y;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] hx;
        logic signed [15:0] hy;
        logic [15:0]        depth;
    } stack_entry_t;

    typedef enum logic [1:0] {
        BK_EXEC,
        BK_VERT2,
        BK_TURN2,
        BK_POP2
    } back_state_t;

endpackage

@@ rtl/tpi_sym_if.sv @@
interface tpi_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       restart;

    modport source (output valid, output symbol, output restart, input ready);
    modport sink   (input valid, input symbol, input restart, output ready);
endinterface

@@ rtl/tpi_vtx_if.sv @@
interface tpi_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [15:0]        turn_depth;
    logic [1:0]         status;
    logic               last;

    modport source (output valid, output vertex_x, output vertex_y, output turn_depth,
                    output status, output last, input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input turn_depth,
                    input status, input last, output ready);
endinterface

@@ rtl/tpi_cfg_if.sv @@
interface tpi_cfg_if;
    import tpi_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/tpi_front.sv @@
module tpi_front (
    tpi_sym_if.sink               symbols,
    output logic                  push_valid,
    input  logic                  push_ready,
    output tpi_pkg::queue_entry_t push_entry
);
    import tpi_pkg::*;

    op_t op;

    // Classify the symbol
    always_comb
    begin
        unique case (symbols.symbol)
            SYM_F, SYM_G: op = OP_DRAW;
            SYM_PUSH:     op = OP_PUSH;
            SYM_POP:      op = OP_POP;
            SYM_PLUS:     op = OP_TURN_PLUS;
            SYM_MINUS:    op = OP_TURN_MINUS;
            default:      op = OP_NONE;
        endcase
    end

    // Drop beats that neither act nor restart
    assign symbols.ready      = push_ready;
    assign push_valid         = symbols.valid && ((op != OP_NONE) || symbols.restart);
    assign push_entry.op      = op;
    assign push_entry.restart = symbols.restart;

endmodule

@@ rtl/tpi_queue.sv @@
module tpi_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tpi_pkg::queue_entry_t in_entry,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tpi_pkg::queue_entry_t out_entry
);
    import tpi_pkg::*;

    queue_entry_t         slots_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   head_reg, head_next;
    logic [Q_PTR_W-1:0]   tail_reg, tail_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign in_ready  = (count_reg != Q_CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = slots_reg[head_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[tail_reg] <= in_entry;
        end
    end

endmodule

@@ rtl/tpi_back.sv @@
module tpi_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tpi_pkg::cfg_t         cfg,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  tpi_pkg::queue_entry_t q_entry,
    tpi_vtx_if.source             vertices
);
    import tpi_pkg::*;

    function automatic logic signed [15:0] round_sat16(input logic signed [33:0] v);
        logic signed [33:0] r;
        r = (v + 34'sd8192) >>> 14;
        if (r > 34'sd32767)
            return 16'sd32767;
        else if (r < -34'sd32768)
            return -16'sd32768;
        else
            return r[15:0];
    endfunction

    function automatic logic signed [31:0] add_sat32(input logic signed [31:0] a,
                                                     input logic signed [15:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31])
            return s[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        else
            return s[31:0];
    endfunction

    back_state_t state_reg, state_next;

    logic signed [31:0]     pos_x_reg, pos_x_next;
    logic signed [31:0]     pos_y_reg, pos_y_next;
    logic signed [15:0]     head_x_reg, head_x_next;
    logic signed [15:0]     head_y_reg, head_y_next;
    logic [15:0]            depth_reg, depth_next;
    logic [STK_LVL_W-1:0]   level_reg, level_next;

    logic signed [31:0]     p_cx_reg, p_cx_next;
    logic signed [31:0]     p_sy_reg, p_sy_next;
    logic signed [31:0]     p_sx_reg, p_sx_next;
    logic signed [31:0]     p_cy_reg, p_cy_next;
    logic                   plus_reg, plus_next;

    logic                   ovalid_reg, ovalid_next;
    logic signed [31:0]     ox_reg, ox_next;
    logic signed [31:0]     oy_reg, oy_next;
    logic [15:0]            odepth_reg, odepth_next;
    logic [1:0]             ostatus_reg, ostatus_next;
    logic                   olast_reg, olast_next;

    stack_entry_t           stack_mem [STACK_DEPTH];
    stack_entry_t           rd_data_reg;
    stack_entry_t           wr_data;
    logic                   wr_en;
    logic [STK_LVL_W-1:0]   level_dec;

    logic signed [31:0]     cur_x, cur_y;
    logic signed [15:0]     cur_hx, cur_hy;
    logic [15:0]            cur_depth;
    logic [STK_LVL_W-1:0]   cur_level;
    logic                   stk_full, stk_empty, need_out, out_free, take;
    logic signed [33:0]     sum_x, sum_y;

    // Turtle as seen by the head op, after an optional restart
    assign cur_x     = q_entry.restart ? '0 : pos_x_reg;
    assign cur_y     = q_entry.restart ? '0 : pos_y_reg;
    assign cur_hx    = q_entry.restart ? cfg.start_dir_x : head_x_reg;
    assign cur_hy    = q_entry.restart ? cfg.start_dir_y : head_y_reg;
    assign cur_depth = q_entry.restart ? DEPTH_ONE : depth_reg;
    assign cur_level = q_entry.restart ? '0 : level_reg;
    assign level_dec = cur_level - 1'b1;

    assign stk_full  = (cur_level == STK_LVL_W'(STACK_DEPTH));
    assign stk_empty = (cur_level == '0);
    assign need_out  = (q_entry.op == OP_DRAW) || ((q_entry.op == OP_PUSH) && stk_full) ||
                       ((q_entry.op == OP_POP) && stk_empty);
    assign out_free  = !ovalid_reg || vertices.ready;
    assign take      = (state_reg == BK_EXEC) && q_valid && (!need_out || out_free);
    assign q_ready   = take;

    assign wr_data.px    = cur_x;
    assign wr_data.py    = cur_y;
    assign wr_data.hx    = cur_hx;
    assign wr_data.hy    = cur_hy;
    assign wr_data.depth = cur_depth;

    assign sum_x = plus_reg ? 34'(p_cx_reg) + 34'(p_sy_reg) : 34'(p_cx_reg) - 34'(p_sy_reg);
    assign sum_y = plus_reg ? 34'(p_cy_reg) - 34'(p_sx_reg) : 34'(p_sx_reg) + 34'(p_cy_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_EXEC:
            begin
                if (take)
                begin
                    unique case (q_entry.op)
                        OP_DRAW:                     state_next = BK_VERT2;
                        OP_POP:                      state_next = stk_empty ? BK_EXEC : BK_POP2;
                        OP_TURN_PLUS, OP_TURN_MINUS: state_next = BK_TURN2;
                        default:                     state_next = BK_EXEC;
                    endcase
                end
            end
            BK_VERT2:
            begin
                if (out_free)
                    state_next = BK_EXEC;
            end
            BK_TURN2: state_next = BK_EXEC;
            BK_POP2:  state_next = BK_EXEC;
            default:  state_next = BK_EXEC;
        endcase
    end

    always_comb
    begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        head_x_next  = head_x_reg;
        head_y_next  = head_y_reg;
        depth_next   = depth_reg;
        level_next   = level_reg;
        p_cx_next    = p_cx_reg;
        p_sy_next    = p_sy_reg;
        p_sx_next    = p_sx_reg;
        p_cy_next    = p_cy_reg;
        plus_next    = plus_reg;
        ovalid_next  = ovalid_reg && !vertices.ready;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        odepth_next  = odepth_reg;
        ostatus_next = ostatus_reg;
        olast_next   = olast_reg;
        wr_en        = 1'b0;

        unique case (state_reg)
            BK_EXEC:
            begin
                if (take)
                begin
                    pos_x_next  = cur_x;
                    pos_y_next  = cur_y;
                    head_x_next = cur_hx;
                    head_y_next = cur_hy;
                    depth_next  = cur_depth;
                    level_next  = cur_level;
                    unique case (q_entry.op)
                        OP_DRAW:
                        begin
                            ovalid_next  = 1'b1;
                            ox_next      = cur_x;
                            oy_next      = cur_y;
                            odepth_next  = cur_depth;
                            ostatus_next = ST_VERTEX;
                            olast_next   = 1'b0;
                            pos_x_next   = add_sat32(cur_x, cur_hx);
                            pos_y_next   = add_sat32(cur_y, cur_hy);
                        end
                        OP_PUSH:
                        begin
                            if (stk_full)
                            begin
                                ovalid_next  = 1'b1;
                                ox_next      = cur_x;
                                oy_next      = cur_y;
                                odepth_next  = cur_depth;
                                ostatus_next = ST_OVERFLOW;
                                olast_next   = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                level_next = cur_level + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (stk_empty)
                            begin
                                ovalid_next  = 1'b1;
                                ox_next      = cur_x;
                                oy_next      = cur_y;
                                odepth_next  = cur_depth;
                                ostatus_next = ST_UNDERFLOW;
                                olast_next   = 1'b1;
                            end
                            else
                            begin
                                level_next = level_dec;
                            end
                        end
                        OP_TURN_PLUS, OP_TURN_MINUS:
                        begin
                            p_cx_next  = cfg.cos_turn * cur_hx;
                            p_sy_next  = cfg.sin_turn * cur_hy;
                            p_sx_next  = cfg.sin_turn * cur_hx;
                            p_cy_next  = cfg.cos_turn * cur_hy;
                            plus_next  = (q_entry.op == OP_TURN_PLUS);
                            depth_next = (cur_depth == DEPTH_MAX) ? cur_depth
                                                                  : cur_depth + 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_VERT2:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    ox_next      = pos_x_reg;
                    oy_next      = pos_y_reg;
                    odepth_next  = depth_reg;
                    ostatus_next = ST_VERTEX;
                    olast_next   = 1'b1;
                end
            end
            BK_TURN2:
            begin
                head_x_next = round_sat16(sum_x);
                head_y_next = round_sat16(sum_y);
            end
            BK_POP2:
            begin
                pos_x_next  = rd_data_reg.px;
                pos_y_next  = rd_data_reg.py;
                head_x_next = rd_data_reg.hx;
                head_y_next = rd_data_reg.hy;
                depth_next  = rd_data_reg.depth;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_EXEC;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            head_x_reg <= START_DIR_X_RESET;
            head_y_reg <= START_DIR_Y_RESET;
            depth_reg  <= DEPTH_ONE;
            level_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            head_x_reg <= head_x_next;
            head_y_reg <= head_y_next;
            depth_reg  <= depth_next;
            level_reg  <= level_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_cx_reg    <= p_cx_next;
        p_sy_reg    <= p_sy_next;
        p_sx_reg    <= p_sx_next;
        p_cy_reg    <= p_cy_next;
        plus_reg    <= plus_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        odepth_reg  <= odepth_next;
        ostatus_reg <= ostatus_next;
        olast_reg   <= olast_next;
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[cur_level[STK_IDX_W-1:0]] <= wr_data;
        end
        rd_data_reg <= stack_mem[level_dec[STK_IDX_W-1:0]];
    end

    assign vertices.valid      = ovalid_reg;
    assign vertices.vertex_x   = ox_reg;
    assign vertices.vertex_y   = oy_reg;
    assign vertices.turn_depth = odepth_reg;
    assign vertices.status     = ostatus_reg;
    assign vertices.last       = olast_reg;

endmodule

@@ rtl/turtle_path_interpreter.sv @@
// Channel    Dir  Beat payload                                     Accepted when
// symbols    in   symbol[7:0], restart                             valid && ready
// vertices   out  vertex_x, vertex_y, turn_depth, status, last     valid && ready
// cfg        in   index[1:0], data[15:0]                           valid && ready
//
// A draw symbol uses executor states BK_EXEC and BK_VERT2 (one per vertex beat), a turn
// BK_EXEC and BK_TURN2 (multiply, then round), a pop BK_EXEC and BK_POP2 (stack read);
// a push, a restart-only beat or a stack error BK_EXEC alone. The front drops others.
// Reset (rst_n low, asynchronous): turtle at origin, start heading, depth 1, empty stack,
// registers at their defaults; the stack memory itself is not cleared.
// The symbol and vertex sides stall independently through a four-entry op queue and
// an output register.
module turtle_path_interpreter (
    input  logic      clk,
    input  logic      rst_n,
    tpi_sym_if.sink   symbols,
    tpi_vtx_if.source vertices,
    tpi_cfg_if.sink   cfg
);
    import tpi_pkg::*;

    cfg_t         cfg_reg, cfg_next;
    logic         push_valid, push_ready;
    queue_entry_t push_entry;
    logic         q_valid, q_ready;
    queue_entry_t q_entry;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_COS_TURN:    cfg_next.cos_turn    = cfg.data;
                CFG_SIN_TURN:    cfg_next.sin_turn    = cfg.data;
                CFG_START_DIR_X: cfg_next.start_dir_x = cfg.data;
                CFG_START_DIR_Y: cfg_next.start_dir_y = cfg.data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_turn    <= COS_TURN_RESET;
            cfg_reg.sin_turn    <= SIN_TURN_RESET;
            cfg_reg.start_dir_x <= START_DIR_X_RESET;
            cfg_reg.start_dir_y <= START_DIR_Y_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classify symbols, drop those with no effect
    tpi_front u_front (
        .symbols    (symbols),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Op queue: decouple the front from the executor
    tpi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_entry  (push_entry),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_entry (q_entry)
    );

    // Executor: turtle state, stack, rotation and vertex output
    tpi_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_entry  (q_entry),
        .vertices (vertices)
    );

endmodule
